@@ design/cbd_pkg.sv @@
package cbd_pkg;

	// Default sample width
	localparam int SAMPLE_BITS_DEF = 16;

	// Register and field widths
	localparam int BAUD_W    = 22;
	localparam int COUNT_W   = 8;
	localparam int ERR_W     = 16;
	localparam int DIV_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = BAUD_W;
	// baud_rate >> 6 gives the divider's denominator
	localparam int BAUD_SHIFT = 6;
	localparam int DEN_W      = BAUD_W - BAUD_SHIFT;

	// Register reset values
	localparam logic [BAUD_W-1:0]  BAUD_RST    = BAUD_W'(57600);
	localparam logic [COUNT_W-1:0] MATCH_RST   = COUNT_W'(100);
	localparam logic [ERR_W-1:0]   ERR_RST     = ERR_W'(1);
	localparam logic [COUNT_W-1:0] ATTEMPT_RST = COUNT_W'(255);

	// Saturation limit of the sample and stable counters
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [DIV_W-1:0]   DIV_MAX   = '1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BAUD_RATE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_TARGET  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERROR     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 2'd3;

	typedef enum logic [1:0] {
		STATUS_MEASURING = 2'd0,
		STATUS_LOCKED    = 2'd1,
		STATUS_LIMIT     = 2'd2,
		STATUS_IGNORED   = 2'd3
	} cbd_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_SCALE,
		ST_FINISH
	} cbd_state_t;

endpackage

@@ design/clock_calibration_baud_divisor.sv @@
// Path from accept to out_valid: a restart or an ignored sample goes straight to FINISH; a
// sample that keeps measuring (or finishes with baud_rate below 64) passes CHECK first; a
// finishing sample passes CHECK, DIVIDE (the one-bit-per-cycle restoring divider) and SCALE.
// Throughput: one word at a time; in_stall is high from accept until the result is loaded
// into the output register, and FINISH waits while out_stall holds a pending result.
// Reset: arst_n resets the sequencer, calibration state, config registers and out_valid at once.
module clock_calibration_baud_divisor #(
	parameter int SAMPLE_BITS = cbd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [cbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbd_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [SAMPLE_BITS-1:0]        sample,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [cbd_pkg::DIV_W-1:0]     divisor,
	output logic                          divisor_underflow,
	output logic [cbd_pkg::COUNT_W-1:0]   stable_seen
);

	localparam int CMP_W = SAMPLE_BITS + cbd_pkg::ERR_W;
	localparam int QX_W  = SAMPLE_BITS + cbd_pkg::DIV_W + 1;
	localparam int CNT_W = $clog2(SAMPLE_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_BITS - 1);

	cbd_pkg::cbd_state_t state_q, state_d;

	// configuration registers
	logic [cbd_pkg::BAUD_W-1:0]  baud_q;
	logic [cbd_pkg::COUNT_W-1:0] match_q;
	logic [cbd_pkg::ERR_W-1:0]   max_err_q;
	logic [cbd_pkg::COUNT_W-1:0] attempt_lim_q;

	// calibration state
	logic [cbd_pkg::COUNT_W-1:0] stable_q;
	logic [cbd_pkg::COUNT_W-1:0] attempts_q;
	logic [SAMPLE_BITS-1:0]      low_q;
	logic [SAMPLE_BITS-1:0]      high_q;
	logic [SAMPLE_BITS-1:0]      last_q;
	logic                        finished_q;

	// divider
	logic [cbd_pkg::DEN_W-1:0]   rem_q;
	logic [SAMPLE_BITS-1:0]      quo_q;
	logic [CNT_W-1:0]            cnt_q;

	// pending result
	cbd_pkg::cbd_status_t        res_status_q;
	logic [cbd_pkg::DIV_W-1:0]   res_div_q;
	logic                        res_under_q;

	// output register
	logic                        out_valid_q;
	logic [1:0]                  out_status_q;
	logic [cbd_pkg::DIV_W-1:0]   out_div_q;
	logic                        out_under_q;
	logic [cbd_pkg::COUNT_W-1:0] out_stable_q;

	logic                        in_acc;
	logic                        out_acc;
	logic                        load_out;
	logic [cbd_pkg::DEN_W-1:0]   den;
	logic                        den_zero;
	logic [SAMPLE_BITS-1:0]      spread;
	logic                        in_range;
	logic [cbd_pkg::COUNT_W-1:0] stable_nxt;
	logic                        fin_lock;
	logic                        fin_limit;
	logic [cbd_pkg::DEN_W:0]     shl;
	logic                        ge;
	logic [SAMPLE_BITS-1:0]      qm1;
	logic [QX_W-1:0]             qm1_ext;
	logic                        q_ovf;

	// Decode the handshakes and shared arithmetic
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign den      = baud_q[cbd_pkg::BAUD_W-1:cbd_pkg::BAUD_SHIFT];
	assign den_zero = (den == '0);

	// Window spread check and the lock / give-up decision
	assign spread     = high_q - low_q;
	assign in_range   = (high_q >= low_q) && (CMP_W'(spread) <= CMP_W'(max_err_q));
	assign stable_nxt = !in_range ? '0 :
		(stable_q < cbd_pkg::COUNT_MAX) ? stable_q + 1'b1 : stable_q;
	assign fin_lock   = (stable_nxt >= match_q);
	assign fin_limit  = (attempts_q >= attempt_lim_q);

	// Restoring divider step: one quotient bit a cycle
	assign shl = {rem_q, quo_q[SAMPLE_BITS-1]};
	assign ge  = (shl >= {1'b0, den});

	// Quotient minus one, saturated to the divisor width
	assign qm1     = quo_q - 1'b1;
	assign qm1_ext = QX_W'(qm1);
	assign q_ovf   = |(qm1_ext >> cbd_pkg::DIV_W);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cbd_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (cmd || finished_q)
						state_d = cbd_pkg::ST_FINISH;
					else
						state_d = cbd_pkg::ST_CHECK;
				end
			end
			cbd_pkg::ST_CHECK: begin
				if ((fin_lock || fin_limit) && !den_zero)
					state_d = cbd_pkg::ST_DIVIDE;
				else
					state_d = cbd_pkg::ST_FINISH;
			end
			cbd_pkg::ST_DIVIDE: begin
				if (cnt_q == CNT_LAST)
					state_d = cbd_pkg::ST_SCALE;
			end
			cbd_pkg::ST_SCALE: begin
				state_d = cbd_pkg::ST_FINISH;
			end
			cbd_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall)
					state_d = cbd_pkg::ST_IDLE;
			end
			default: state_d = cbd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		load_out = 1'b0;
		unique case (state_q)
			cbd_pkg::ST_IDLE:   in_stall = 1'b0;
			cbd_pkg::ST_FINISH: load_out = !out_valid_q || !out_stall;
			default: begin
				in_stall = 1'b1;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cbd_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_q        <= cbd_pkg::BAUD_RST;
			match_q       <= cbd_pkg::MATCH_RST;
			max_err_q     <= cbd_pkg::ERR_RST;
			attempt_lim_q <= cbd_pkg::ATTEMPT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbd_pkg::REG_BAUD_RATE:     baud_q        <= cfg_data;
				cbd_pkg::REG_MATCH_TARGET:  match_q       <= cfg_data[cbd_pkg::COUNT_W-1:0];
				cbd_pkg::REG_MAX_ERROR:     max_err_q     <= cfg_data[cbd_pkg::ERR_W-1:0];
				cbd_pkg::REG_ATTEMPT_LIMIT: attempt_lim_q <= cfg_data[cbd_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Calibration state: restart on a command, or take a sample, then check the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q   <= '0;
			attempts_q <= '0;
			low_q      <= '1;
			high_q     <= '0;
			last_q     <= '0;
			finished_q <= 1'b0;
		end else if (state_q == cbd_pkg::ST_IDLE && in_acc) begin
			if (cmd) begin
				stable_q   <= '0;
				attempts_q <= '0;
				low_q      <= '1;
				high_q     <= '0;
				last_q     <= '0;
				finished_q <= 1'b0;
			end else if (!finished_q) begin
				last_q <= sample;
				if (sample < low_q)
					low_q <= sample;
				if (sample > high_q)
					high_q <= sample;
				if (attempts_q < cbd_pkg::COUNT_MAX)
					attempts_q <= attempts_q + 1'b1;
			end
		end else if (state_q == cbd_pkg::ST_CHECK) begin
			stable_q <= stable_nxt;
			if (!in_range) begin
				low_q  <= '1;
				high_q <= '0;
			end
			if (fin_lock || fin_limit)
				finished_q <= 1'b1;
		end
	end

	// Result fields and the divider
	always_ff @(posedge clk) begin
		unique case (state_q)
			cbd_pkg::ST_IDLE: begin
				res_status_q <= cbd_pkg::STATUS_IGNORED;
				res_div_q    <= '0;
				res_under_q  <= 1'b0;
			end
			cbd_pkg::ST_CHECK: begin
				res_under_q <= 1'b0;
				if (fin_lock)
					res_status_q <= cbd_pkg::STATUS_LOCKED;
				else if (fin_limit)
					res_status_q <= cbd_pkg::STATUS_LIMIT;
				else
					res_status_q <= cbd_pkg::STATUS_MEASURING;
				res_div_q <= ((fin_lock || fin_limit) && den_zero) ? cbd_pkg::DIV_MAX : '0;
				rem_q <= '0;
				quo_q <= last_q;
				cnt_q <= '0;
			end
			cbd_pkg::ST_DIVIDE: begin
				rem_q <= ge ? cbd_pkg::DEN_W'(shl - {1'b0, den}) : shl[cbd_pkg::DEN_W-1:0];
				quo_q <= {quo_q[SAMPLE_BITS-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			cbd_pkg::ST_SCALE: begin
				if (quo_q == '0) begin
					res_div_q   <= '0;
					res_under_q <= 1'b1;
				end else if (q_ovf) begin
					res_div_q <= cbd_pkg::DIV_MAX;
				end else begin
					res_div_q <= qm1_ext[cbd_pkg::DIV_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// Output register: load the result, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_acc)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_div_q    <= res_div_q;
			out_under_q  <= res_under_q;
			out_stable_q <= stable_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign divisor           = out_div_q;
	assign divisor_underflow = out_under_q;
	assign stable_seen       = out_stable_q;

`ifndef SYNTHESIS
	// A result that does not finish calibration carries no divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == cbd_pkg::STATUS_MEASURING ||
			out_status_q == cbd_pkg::STATUS_IGNORED) |-> out_div_q == '0 && !out_under_q)
		else $error("divisor set on a non-finishing result");

	// Saturation to zero is the only source of the underflow flag
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_under_q |-> out_div_q == '0)
		else $error("underflow flagged with a nonzero divisor");

	// Calibration finishes only out of the window check
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(finished_q) |-> $past(state_q) == cbd_pkg::ST_CHECK)
		else $error("finished set outside the window check");

	// The divider never runs on a zero denominator
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cbd_pkg::ST_DIVIDE |-> !den_zero)
		else $error("divider running with zero denominator");
`endif

endmodule
